/* rtl/core/json_top_level_key_extractor_defines.svh */
// Assertion macros for the key extractor RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef JSON_TOP_LEVEL_KEY_EXTRACTOR_DEFINES_SVH
`define JSON_TOP_LEVEL_KEY_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JKX_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key extractor check failed");

// Next-cycle implication, checked outside reset.
`define JKX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key extractor check failed");

`endif

/* rtl/core/jkx_pkg.sv */
// Package for the JSON top-level key extractor: payload types, codes, sizes.
// No dependencies; every RTL module of the block uses it.
`timescale 1ns / 1ps

package jkx_pkg;

	localparam int KEY_BYTES_DEF = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int KEY_LEN_W = 6;
	localparam int OQ_DEPTH = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 3'd1;

	// Result status codes.
	localparam logic [1:0] ST_CHAR = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	typedef struct packed {
		logic [7:0] in_char;
		logic       doc_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic [1:0] status;
		logic       result_last;
	} out_item_t;

	// Results of one parsed item: a count of zero to two and the items.
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  first;
		out_item_t  second;
	} res_grp_t;

endpackage

/* rtl/core/jkx_cfg.sv */
// Configuration registers: key length and the key bytes.
// Depends on jkx_pkg.
`timescale 1ns / 1ps

module jkx_cfg #(
	parameter int KEY_BYTES = jkx_pkg::KEY_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [jkx_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [jkx_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [jkx_pkg::KEY_LEN_W-1:0]       key_length,
	output logic [KEY_BYTES-1:0][7:0]           key_bytes
);

	logic [jkx_pkg::KEY_LEN_W-1:0] key_length_q;
	logic [KEY_BYTES-1:0][7:0]     key_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= '0;
		end else if (cfg_we && cfg_index == jkx_pkg::REG_KEY_LENGTH) begin
			key_length_q <= cfg_data[jkx_pkg::KEY_LEN_W-1:0];
		end
	end

	// Each key byte lives in one word register; bytes past KEY_BYTES are not kept.
	for (genvar i = 0; i < KEY_BYTES; i++) begin : g_byte
		localparam logic [jkx_pkg::CFG_INDEX_W-1:0] WordIdx =
			jkx_pkg::REG_KEY_WORD0 + jkx_pkg::CFG_INDEX_W'(i / 8);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				key_bytes_q[i] <= '0;
			end else if (cfg_we && cfg_index == WordIdx) begin
				key_bytes_q[i] <= cfg_data[(i % 8) * 8 +: 8];
			end
		end
	end

	assign key_length = key_length_q;
	assign key_bytes = key_bytes_q;

endmodule

/* rtl/core/jkx_parse.sv */
// Input register and per-character parser state machine.
// Depends on jkx_pkg; produces zero to two result items per input item.
`timescale 1ns / 1ps

module jkx_parse #(
	parameter int KEY_BYTES = jkx_pkg::KEY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  jkx_pkg::in_item_t             in_data,
	input  logic [jkx_pkg::KEY_LEN_W-1:0] key_length,
	input  logic [KEY_BYTES-1:0][7:0]     key_bytes,
	input  logic                          space_ok,
	output jkx_pkg::res_grp_t             res
);

	localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;

	localparam logic [15:0] DEPTH_MAX = 16'h7FFF;
	localparam logic [15:0] DEPTH_MIN = 16'h8000;
	localparam logic [jkx_pkg::KEY_LEN_W-1:0] KPOS_MAX = '1;

	typedef enum logic [7:0] {
		PH_SCAN  = 8'b0000_0001,
		PH_STR   = 8'b0000_0010,
		PH_KEY   = 8'b0000_0100,
		PH_COLON = 8'b0000_1000,
		PH_PRE   = 8'b0001_0000,
		PH_QVAL  = 8'b0010_0000,
		PH_UVAL  = 8'b0100_0000,
		PH_DONE  = 8'b1000_0000
	} phase_t;

	function automatic logic is_ws(input logic [7:0] ch);
		return ch == 8'h20 || ch == 8'h09 || ch == 8'h0A || ch == 8'h0B ||
			ch == 8'h0C || ch == 8'h0D;
	endfunction

	logic                          s1_valid_q;
	jkx_pkg::in_item_t             in_data_s1;
	phase_t                        phase_q, n_phase;
	logic                          esc_q, n_esc;
	logic [15:0]                   depth_q, n_depth;
	logic [jkx_pkg::KEY_LEN_W-1:0] kpos_q, n_kpos;
	logic                          keq_q, n_keq;

	logic       proc, load;
	logic [7:0] c;
	logic       last;
	logic       do_scan, do_kbyte, fin, kb_ok;
	logic       e0_v, e1_v;
	logic [7:0] e0_ch;
	logic [1:0] e0_st, e1_st;

	assign proc = s1_valid_q && space_ok;
	assign in_stall = s1_valid_q && !space_ok;
	assign load = in_valid && !in_stall;
	assign c = in_data_s1.in_char;
	assign last = in_data_s1.doc_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (load) begin
			s1_valid_q <= 1'b1;
		end else if (proc) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			in_data_s1 <= in_data;
		end
	end

	// The key byte compare only looks at the store when the position is in range.
	assign kb_ok = (kpos_q < jkx_pkg::KEY_LEN_W'(KEY_BYTES)) && (kpos_q < key_length) &&
		(key_bytes[kpos_q[KIDX_W-1:0]] == c);

	always_comb begin
		n_phase = phase_q;
		n_esc = esc_q;
		n_depth = depth_q;
		n_kpos = kpos_q;
		n_keq = keq_q;
		do_scan = 1'b0;
		do_kbyte = 1'b0;
		fin = 1'b0;
		e0_v = 1'b0;
		e0_ch = '0;
		e0_st = jkx_pkg::ST_CHAR;
		e1_v = 1'b0;
		e1_st = jkx_pkg::ST_NONE;

		case (phase_q)
			PH_SCAN: begin
				do_scan = 1'b1;
			end
			PH_STR: begin
				if (esc_q) begin
					n_esc = 1'b0;
				end else if (c == CH_BSLASH) begin
					n_esc = 1'b1;
				end else if (c == CH_QUOTE) begin
					n_phase = PH_SCAN;
				end
			end
			PH_KEY: begin
				if (esc_q) begin
					n_esc = 1'b0;
					do_kbyte = 1'b1;
				end else if (c == CH_BSLASH) begin
					n_esc = 1'b1;
					do_kbyte = 1'b1;
				end else if (c == CH_QUOTE) begin
					n_keq = keq_q && (kpos_q == key_length);
					n_phase = PH_COLON;
				end else begin
					do_kbyte = 1'b1;
				end
			end
			PH_COLON: begin
				if (is_ws(c)) begin
					n_phase = PH_COLON;
				end else if (c == CH_COLON) begin
					n_phase = keq_q ? PH_PRE : PH_SCAN;
				end else begin
					// Not a key after all: the character is scanned as ordinary input.
					n_phase = PH_SCAN;
					do_scan = 1'b1;
				end
			end
			PH_PRE: begin
				if (is_ws(c)) begin
					n_phase = PH_PRE;
				end else if (c == CH_QUOTE) begin
					n_phase = PH_QVAL;
					n_esc = 1'b0;
				end else if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACKET) begin
					e0_v = 1'b1;
					e0_st = jkx_pkg::ST_NONE;
					fin = 1'b1;
				end else begin
					e0_v = 1'b1;
					e0_ch = c;
					n_phase = PH_UVAL;
				end
			end
			PH_QVAL: begin
				if (esc_q) begin
					n_esc = 1'b0;
					e0_v = 1'b1;
					e0_ch = c;
				end else if (c == CH_BSLASH) begin
					n_esc = 1'b1;
				end else if (c == CH_QUOTE) begin
					e0_v = 1'b1;
					e0_st = jkx_pkg::ST_DONE;
					fin = 1'b1;
				end else begin
					e0_v = 1'b1;
					e0_ch = c;
				end
			end
			PH_UVAL: begin
				if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACKET || is_ws(c)) begin
					e0_v = 1'b1;
					e0_st = jkx_pkg::ST_DONE;
					fin = 1'b1;
				end else begin
					e0_v = 1'b1;
					e0_ch = c;
				end
			end
			default: begin
				n_phase = phase_q;
			end
		endcase

		if (do_scan) begin
			if (c == CH_QUOTE) begin
				n_esc = 1'b0;
				if (depth_q == 16'd1) begin
					n_phase = PH_KEY;
					n_kpos = '0;
					n_keq = 1'b1;
				end else begin
					n_phase = PH_STR;
				end
			end else if (c == CH_LBRACE && depth_q != DEPTH_MAX) begin
				n_depth = depth_q + 16'd1;
			end else if (c == CH_RBRACE && depth_q != DEPTH_MIN) begin
				n_depth = depth_q - 16'd1;
			end
		end

		if (do_kbyte) begin
			n_keq = keq_q && kb_ok;
			n_kpos = (kpos_q == KPOS_MAX) ? kpos_q : kpos_q + 1'b1;
		end

		if (fin) begin
			n_phase = PH_DONE;
		end

		// The end of a document closes it with one status item unless the value is already done.
		if (last) begin
			if (n_phase == PH_UVAL) begin
				e1_v = 1'b1;
				e1_st = jkx_pkg::ST_DONE;
			end else if (n_phase != PH_DONE) begin
				e1_v = 1'b1;
				e1_st = jkx_pkg::ST_NONE;
			end
			n_phase = PH_SCAN;
			n_esc = 1'b0;
			n_depth = '0;
			n_kpos = '0;
			n_keq = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			esc_q <= 1'b0;
			depth_q <= '0;
			kpos_q <= '0;
			keq_q <= 1'b1;
		end else if (proc) begin
			phase_q <= n_phase;
			esc_q <= n_esc;
			depth_q <= n_depth;
			kpos_q <= n_kpos;
			keq_q <= n_keq;
		end
	end

	always_comb begin
		res.cnt = '0;
		res.first = '0;
		res.second = '0;
		if (proc) begin
			if (e0_v) begin
				res.first.out_char = e0_ch;
				res.first.status = e0_st;
				res.first.result_last = !e1_v;
				res.second.status = e1_st;
				res.second.result_last = 1'b1;
				res.cnt = e1_v ? 2'd2 : 2'd1;
			end else if (e1_v) begin
				res.first.status = e1_st;
				res.first.result_last = 1'b1;
				res.cnt = 2'd1;
			end
		end
	end

endmodule

/* rtl/core/jkx_outq.sv */
// Result queue: takes up to two result items a cycle, hands out one unless out_stall is high.
// Depends on jkx_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "json_top_level_key_extractor_defines.svh"

module jkx_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  jkx_pkg::res_grp_t   res,
	output logic                space_ok,
	output logic                out_valid,
	input  logic                out_stall,
	output jkx_pkg::out_item_t  out_data
);

	localparam int PTR_W = $clog2(jkx_pkg::OQ_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	jkx_pkg::out_item_t mem_q [jkx_pkg::OQ_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign wr_ptr1 = wr_ptr_q + 1'b1;
	assign out_valid = count_q != '0;
	assign out_data = mem_q[rd_ptr_q];
	assign pop = out_valid && !out_stall;
	// Room for the worst case of two results from the next item.
	assign space_ok = count_q <= CNT_W'(jkx_pkg::OQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (res.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= res.first;
		end
		if (res.cnt == 2'd2) begin
			mem_q[wr_ptr1] <= res.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(res.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(res.cnt) - CNT_W'(pop);
		end
	end

	`JKX_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(jkx_pkg::OQ_DEPTH))
	`JKX_ASSERT_NOW(a_pair_fits, res.cnt == 2'd2, count_q <= CNT_W'(jkx_pkg::OQ_DEPTH - 2))
	`JKX_ASSERT_NEXT(a_pop_only, pop && res.cnt == 2'd0, count_q == $past(count_q) - 1'b1)
	`JKX_ASSERT_NEXT(a_ptr_gap, 1'b1, PTR_W'(wr_ptr_q - rd_ptr_q) == count_q[PTR_W-1:0])

endmodule

/* rtl/core/json_top_level_key_extractor.sv */
// JSON top-level key extractor: streams the value of a configured depth-one key.
// With an empty result queue, an accepted item is held in the input register, and its results
// are written into the result queue, from which the first is offered on out_data.
// Throughput: 1 item per cycle while the result queue has room; results leave one per cycle
// unless out_stall is high, and input stalls while the 4-entry queue holds more than 2.
// Reset: arst_n clears parser state, key registers and the result queue at once.
`timescale 1ns / 1ps

module json_top_level_key_extractor #(
	parameter int KEY_BYTES = jkx_pkg::KEY_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  jkx_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output jkx_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [jkx_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [jkx_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [jkx_pkg::KEY_LEN_W-1:0] key_length;
	logic [KEY_BYTES-1:0][7:0]     key_bytes;
	logic                          space_ok;
	jkx_pkg::res_grp_t             res;

	jkx_cfg #(
		.KEY_BYTES(KEY_BYTES)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.key_length(key_length),
		.key_bytes(key_bytes)
	);

	jkx_parse #(
		.KEY_BYTES(KEY_BYTES)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.key_length(key_length),
		.key_bytes(key_bytes),
		.space_ok(space_ok),
		.res(res)
	);

	jkx_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.res(res),
		.space_ok(space_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
